// ===== rtl/nco_complex_mixer_assert.svh =====
// Assertion macros shared by the mixer RTL.
// Define ASSERT_OFF to compile them out.
`ifndef NCO_COMPLEX_MIXER_ASSERT_SVH
`define NCO_COMPLEX_MIXER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define NCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define NCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define NCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ncm_pkg.sv =====
package ncm_pkg;

   // Default geometry
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int PHASE_WIDTH_DEF     = 32;
   localparam int TABLE_ADDR_BITS_DEF = 10;

   // Fixed formats
   localparam int STEP_W    = 32;  // phase step register
   localparam int TAB_VAL_W = 15;  // stored table magnitude 0..32767
   localparam int TAB_W     = 16;  // signed sine/cosine operand
   localparam int FRAC_BITS = 15;  // Q1.15 scaling of the table

   // Sine table generation: pi/2 in Q2.30 and Taylor term divisors (2k)(2k+1)
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SERIES_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };
   localparam logic [TAB_VAL_W-1:0] TAB_MAX = {TAB_VAL_W{1'b1}};

   typedef enum logic [1:0] {
      QUAD_I   = 2'd0,
      QUAD_II  = 2'd1,
      QUAD_III = 2'd2,
      QUAD_IV  = 2'd3
   } quad_type;

   // One quarter-wave entry, 32767*sin(idx*pi/2/2^addr_bits); evaluated at elaboration
   function automatic logic [TAB_VAL_W-1:0] sine_entry(input int unsigned idx,
                                                       input int unsigned addr_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] s;
      logic [63:0]        e;
      x  = (64'(idx) * HALF_PI_Q30) >> addr_bits;
      x2 = (x * x) >> 30;
      t  = x;
      s  = signed'(x);
      for (int k = 0; k < 12; k++) begin
         t = ((t * x2) >> 30) / SERIES_DIV[k];
         if (k % 2 == 0) begin
            s = s - signed'(t);
         end else begin
            s = s + signed'(t);
         end
      end
      if (s < 0) begin
         s = '0;
      end
      e = (unsigned'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'(TAB_MAX)) begin
         e = 64'(TAB_MAX);
      end
      return e[TAB_VAL_W-1:0];
   endfunction

endpackage

// ===== rtl/ncm_ram.sv =====
module ncm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/ncm_fill.sv =====
`include "nco_complex_mixer_assert.svh"

module ncm_fill
   import ncm_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       wr_en,
   output logic [TABLE_ADDR_BITS:0]   wr_addr,
   output logic [TAB_VAL_W-1:0]       wr_data,
   output logic                       done
);

   localparam int TAB_LEN = (1 << TABLE_ADDR_BITS) + 1;
   localparam logic [TABLE_ADDR_BITS:0] LAST = (TABLE_ADDR_BITS + 1)'(TAB_LEN - 1);

   logic [TAB_VAL_W-1:0]     tab_rom [TAB_LEN];
   logic                     active_ff;
   logic                     active_in;
   logic [TABLE_ADDR_BITS:0] cnt_ff;
   logic [TABLE_ADDR_BITS:0] cnt_in;
   logic                     wr_en_ff;
   logic                     wr_en_in;
   logic [TABLE_ADDR_BITS:0] wr_addr_ff;
   logic [TAB_VAL_W-1:0]     wr_data_ff;

   // Constant quarter-wave contents, worked out at elaboration
   for (genvar g = 0; g < TAB_LEN; g++) begin : g_rom
      localparam logic [TAB_VAL_W-1:0] ENTRY = sine_entry(g, TABLE_ADDR_BITS);
      assign tab_rom[g] = ENTRY;
   end

   // Sweep the table into the RAM once after reset
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      wr_en_in  = 1'b0;
      if (active_ff) begin
         wr_en_in = 1'b1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
         wr_en_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         wr_en_ff  <= wr_en_in;
      end
   end

   // Write address and data, registered after the constant lookup
   always_ff @(posedge clock) begin
      wr_addr_ff <= cnt_ff;
      wr_data_ff <= tab_rom[cnt_ff];
   end

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
   assign done    = !active_ff && !wr_en_ff;

   `NCM_ASSERT_NXT(a_fill_addr_step, clock, reset, wr_en_ff && wr_en_in,
      wr_addr_ff == $past(wr_addr_ff) + 1'b1, "table load skipped an address")
   `NCM_ASSERT_IMP(a_fill_done_quiet, clock, reset, done, !wr_en_ff && !active_ff,
      "table write after load finished")

endmodule

// ===== rtl/ncm_mixer.sv =====
`include "nco_complex_mixer_assert.svh"

module ncm_mixer
   import ncm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           s1_valid,
   input  quad_type                       s1_quad,
   input  logic signed [SAMPLE_WIDTH-1:0] s1_re,
   input  logic signed [SAMPLE_WIDTH-1:0] s1_im,
   input  logic [TAB_VAL_W-1:0]           tab_lo,
   input  logic [TAB_VAL_W-1:0]           tab_hi,
   output logic                           s1_take,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_re,
   output logic signed [SAMPLE_WIDTH-1:0] out_im
);

   localparam int PROD_W = SAMPLE_WIDTH + TAB_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int TOP_W  = SUM_W - FRAC_BITS - SAMPLE_WIDTH + 1;
   localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic                     en2;
   logic                     en3;
   logic signed [TAB_W-1:0]  lo_s;
   logic signed [TAB_W-1:0]  hi_s;
   logic signed [TAB_W-1:0]  sin_val;
   logic signed [TAB_W-1:0]  cos_val;
   logic                     v2_ff;
   logic                     v3_ff;
   logic signed [PROD_W-1:0] p_rc_ff;
   logic signed [PROD_W-1:0] p_is_ff;
   logic signed [PROD_W-1:0] p_rs_ff;
   logic signed [PROD_W-1:0] p_ic_ff;
   logic signed [SUM_W-1:0]  sum_re;
   logic signed [SUM_W-1:0]  sum_im;
   logic signed [SAMPLE_WIDTH-1:0] out_re_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_im_ff;

   // Drop the rounding fraction and clamp to the sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [SUM_W-1:0] v);
      logic [TOP_W-1:0] top;
      top = v[SUM_W-1 -: TOP_W];
      if (&top || ~|top) begin
         return v[FRAC_BITS +: SAMPLE_WIDTH];
      end else if (v[SUM_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   // Stage advance: each stage moves when the one after it is empty or moving
   assign en3     = !v3_ff || rsp_ready;
   assign en2     = !v2_ff || en3;
   assign s1_take = en2;

   // Fold the quarter-wave entries into sine and cosine
   always_comb begin
      lo_s = signed'({1'b0, tab_lo});
      hi_s = signed'({1'b0, tab_hi});
      case (s1_quad)
         QUAD_I: begin
            sin_val = lo_s;
            cos_val = hi_s;
         end
         QUAD_II: begin
            sin_val = hi_s;
            cos_val = -lo_s;
         end
         QUAD_III: begin
            sin_val = -lo_s;
            cos_val = -hi_s;
         end
         QUAD_IV: begin
            sin_val = -hi_s;
            cos_val = lo_s;
         end
         default: begin
            sin_val = '0;
            cos_val = '0;
         end
      endcase
   end

   // Stage 2: four products
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid) begin
         p_rc_ff <= s1_re * cos_val;
         p_is_ff <= s1_im * sin_val;
         p_rs_ff <= s1_re * sin_val;
         p_ic_ff <= s1_im * cos_val;
      end
   end

   // Stage 3: combine, round, saturate into the output register
   assign sum_re = SUM_W'(p_rc_ff) - SUM_W'(p_is_ff) + RND;
   assign sum_im = SUM_W'(p_rs_ff) + SUM_W'(p_ic_ff) + RND;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         out_re_ff <= round_sat(sum_re);
         out_im_ff <= round_sat(sum_im);
      end
   end

   assign rsp_valid = v3_ff;
   assign out_re    = out_re_ff;
   assign out_im    = out_im_ff;

   `NCM_ASSERT_NXT(a_mix_hold_s2, clock, reset, v2_ff && v3_ff && !rsp_ready, v2_ff,
      "product stage lost a word under stall")
   `NCM_ASSERT_NXT(a_mix_s2_to_s3, clock, reset, v2_ff && en3, v3_ff,
      "product stage word did not reach the output register")

endmodule

// ===== rtl/nco_complex_mixer.sv =====
// Complex frequency shifter: each req word carries one complex Q1.15 sample
// and a restart flag; the block returns the sample multiplied by
// exp(j*2*pi*phase/2^PHASE_WIDTH), rounded half-up and saturated, and then
// advances the phase by the sign-extended csr step (f/Fs * 2^32). A set restart
// flag zeroes the phase before the sample is mixed. Throughput is one word per
// clock while rsp_tready is high and the table is loaded, set by the dual-read
// table RAM that returns both quarter-wave entries of an address together;
// the word passes three register stages: stage 1 with the RAM read, the
// products and the output register. After reset the quarter-wave table is
// loaded into the RAM with req_tready low; csr writes are taken at any time
// and should only be issued while the block is idle.
`include "nco_complex_mixer_assert.svh"

module nco_complex_mixer
   import ncm_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH     = PHASE_WIDTH_DEF,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // in_re, in_im, zero pad to whole bytes
   input  logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // restart
   input  logic [0:0]                                    req_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // out_re, out_im, zero pad to whole bytes
   output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                          csr_wr_en,
   input  logic [STEP_W-1:0]                             csr_wr_data
);

   localparam int DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int ADDR_W  = TABLE_ADDR_BITS + 1;
   localparam int TAB_LEN = (1 << TABLE_ADDR_BITS) + 1;
   localparam int EXT_W   = (PHASE_WIDTH > STEP_W) ? PHASE_WIDTH : STEP_W;
   localparam logic [ADDR_W-1:0] FULL = ADDR_W'(1) << TABLE_ADDR_BITS;

   logic                           accept;
   logic                           fill_done;
   logic                           fill_wr_en;
   logic [ADDR_W-1:0]              fill_wr_addr;
   logic [TAB_VAL_W-1:0]           fill_wr_data;
   logic                           en1;
   logic                           s1_take;
   logic signed [STEP_W-1:0]       step_ff;
   logic [PHASE_WIDTH-1:0]         phase_ff;
   logic [PHASE_WIDTH-1:0]         phase_in;
   logic [PHASE_WIDTH-1:0]         phase_sel;
   logic [EXT_W-1:0]               phase_sum;
   logic [PHASE_WIDTH-1:0]         step_narrow;
   logic [TABLE_ADDR_BITS-1:0]     tab_off;
   logic [ADDR_W-1:0]              addr_lo;
   logic [ADDR_W-1:0]              addr_hi;
   logic [TAB_VAL_W-1:0]           tab_lo;
   logic [TAB_VAL_W-1:0]           tab_hi;
   logic                           v1_ff;
   quad_type                       quad1_ff;
   logic signed [SAMPLE_WIDTH-1:0] re1_ff;
   logic signed [SAMPLE_WIDTH-1:0] im1_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_re;
   logic signed [SAMPLE_WIDTH-1:0] out_im;

   // Phase step register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (csr_wr_en) begin
         step_ff <= signed'(csr_wr_data);
      end
   end

   // Stage 1 takes a word when it is empty or moving on
   assign en1        = !v1_ff || s1_take;
   assign req_tready = fill_done && en1;
   assign accept     = req_tvalid && req_tready;

   // Phase used for this word, then advance by the sign-extended step
   assign phase_sel   = req_tuser[0] ? '0 : phase_ff;
   assign phase_sum   = EXT_W'(phase_sel) + EXT_W'(step_ff);
   assign phase_in    = phase_sum[PHASE_WIDTH-1:0];
   assign step_narrow = PHASE_WIDTH'(EXT_W'(step_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // Table addresses: offset in the quadrant and its mirror
   assign tab_off = phase_sel[PHASE_WIDTH-3 -: TABLE_ADDR_BITS];
   assign addr_lo = {1'b0, tab_off};
   assign addr_hi = FULL - addr_lo;

   // Stage 1 registers, aligned with the RAM read data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         quad1_ff <= quad_type'(phase_sel[PHASE_WIDTH-1 -: 2]);
         re1_ff   <= signed'(req_tdata[SAMPLE_WIDTH-1:0]);
         im1_ff   <= signed'(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      end
   end

   ncm_fill #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
   ) u_fill (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .done    (fill_done)
   );

   ncm_ram #(
      .WIDTH(TAB_VAL_W),
      .DEPTH(TAB_LEN)
   ) u_table (
      .clock     (clock),
      .wr_en     (fill_wr_en),
      .wr_addr   (fill_wr_addr),
      .wr_data   (fill_wr_data),
      .rd_en     (en1),
      .rd_addr_a (addr_lo),
      .rd_addr_b (addr_hi),
      .rd_data_a (tab_lo),
      .rd_data_b (tab_hi)
   );

   ncm_mixer #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_mixer (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (v1_ff),
      .s1_quad   (quad1_ff),
      .s1_re     (re1_ff),
      .s1_im     (im1_ff),
      .tab_lo    (tab_lo),
      .tab_hi    (tab_hi),
      .s1_take   (s1_take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .out_re    (out_re),
      .out_im    (out_im)
   );

   assign rsp_tdata = DATA_W'({out_im, out_re});

   `NCM_ASSERT_IMP(a_top_no_accept_in_load, clock, reset, !fill_done, !req_tready,
      "word accepted while the table loads")
   `NCM_ASSERT_NXT(a_top_restart_phase, clock, reset, accept && req_tuser[0],
      phase_ff == $past(step_narrow), "restart did not zero the phase before the step")

endmodule

// ===== tb/nco_mixer_checker.sv =====
module nco_mixer_checker
   import ncm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   // in_re, in_im
   input  logic [31:0]       req_tdata,
   // restart
   input  logic [0:0]        req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_re, out_im
   input  logic [31:0]       rsp_tdata,
   input  logic              csr_wr_en,
   input  logic [STEP_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                words_in_flight
);

   localparam int SW      = SAMPLE_WIDTH_DEF;
   localparam int PW      = PHASE_WIDTH_DEF;
   localparam int AB      = TABLE_ADDR_BITS_DEF;
   localparam int QUARTER = 1 << AB;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      int                   seq;
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
   } mixed_word_t;

   int            quarter_sine [0:QUARTER];
   mixed_word_t   mixed_due [$];
   logic [PW-1:0] nco_phase;
   logic [STEP_W-1:0] nco_step;
   int            accepted_count;

   // Build the quarter-wave sine table with a 12-term series in Q2.30
   initial begin
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned e;
      longint          s;
      for (int i = 0; i <= QUARTER; i++) begin
         x  = (longint'(i) * 64'd1686629713) >> AB;
         x2 = (x * x) >> 30;
         t  = x;
         s  = longint'(x);
         for (int k = 1; k <= 12; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         e = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (e > 64'd32767) begin
            e = 64'd32767;
         end
         quarter_sine[i] = int'(e);
      end
   end

   initial begin
      fail_count      = 0;
      words_in_flight = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTED) begin
         $display("mixer mismatch: %s", what);
      end
      fail_count = fail_count + 1;
   endtask

   // Round half up back to Q1.15 and clamp to the sample range
   function automatic logic signed [SW-1:0] round_q15(input longint v);
      longint r;
      longint hi;
      hi = (longint'(1) << (SW - 1)) - 1;
      r  = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > hi) begin
         r = hi;
      end
      if (r < -hi - 1) begin
         r = -hi - 1;
      end
      return r[SW-1:0];
   endfunction

   // Multiply one sample by the oscillator value at the given phase
   function automatic mixed_word_t mix_with_nco(input logic [PW-1:0]    ph,
                                                input logic signed [SW-1:0] xr,
                                                input logic signed [SW-1:0] xi);
      quad_type    quad;
      int          addr;
      longint      sn;
      longint      cs;
      mixed_word_t y;
      quad = quad_type'(ph[PW-1 -: 2]);
      addr = int'(ph[PW-3 -: AB]);
      case (quad)
         QUAD_I: begin
            sn = quarter_sine[addr];
            cs = quarter_sine[QUARTER - addr];
         end
         QUAD_II: begin
            sn = quarter_sine[QUARTER - addr];
            cs = -longint'(quarter_sine[addr]);
         end
         QUAD_III: begin
            sn = -longint'(quarter_sine[addr]);
            cs = -longint'(quarter_sine[QUARTER - addr]);
         end
         default: begin
            sn = -longint'(quarter_sine[QUARTER - addr]);
            cs = quarter_sine[addr];
         end
      endcase
      y.seq = 0;
      y.re  = round_q15(longint'(xr) * cs - longint'(xi) * sn);
      y.im  = round_q15(longint'(xr) * sn + longint'(xi) * cs);
      return y;
   endfunction

   // Track the step register, predict each accepted word, check each result
   always @(posedge clock) begin
      mixed_word_t          want;
      logic signed [SW-1:0] got_re;
      logic signed [SW-1:0] got_im;
      logic [PW-1:0]        use_phase;
      if (reset) begin
         nco_phase      = '0;
         nco_step       = '0;
         accepted_count = 0;
         mixed_due.delete();
         words_in_flight <= 0;
      end else begin
         if (csr_wr_en) begin
            nco_step = csr_wr_data;
         end
         // compare against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got_re = rsp_tdata[SW-1:0];
            got_im = rsp_tdata[2*SW-1:SW];
            if (mixed_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word re %0d im %0d", got_re, got_im));
            end else begin
               want = mixed_due.pop_front();
               if (got_re !== want.re) begin
                  report_mismatch($sformatf("word %0d out_re got %0d want %0d",
                                            want.seq, got_re, want.re));
               end
               if (got_im !== want.im) begin
                  report_mismatch($sformatf("word %0d out_im got %0d want %0d",
                                            want.seq, got_im, want.im));
               end
            end
         end
         // mix at the current (or restarted) phase, then advance it
         if (req_tvalid && req_tready) begin
            use_phase = req_tuser[0] ? '0 : nco_phase;
            want      = mix_with_nco(use_phase, req_tdata[SW-1:0], req_tdata[2*SW-1:SW]);
            want.seq  = accepted_count;
            accepted_count = accepted_count + 1;
            mixed_due.push_back(want);
            nco_phase = use_phase + PW'(signed'(nco_step));
         end
         words_in_flight <= mixed_due.size();
      end
   end

endmodule

// ===== tb/tb_nco_complex_mixer.sv =====
module tb_nco_complex_mixer;
   import ncm_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_COUNT   = 13;
   localparam int PHASE_WORDS   = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic [0:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic [STEP_W-1:0] csr_wr_data = '0;

   int fail_count;
   int words_in_flight;
   int cycle_count = 0;
   int holds_asked = 0;
   int holds_done  = 0;
   bit send_quiet  = 1'b0;
   bit recv_quiet  = 1'b0;

   always #4 clock = ~clock;

   nco_complex_mixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   nco_mixer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .words_in_flight (words_in_flight)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_nco_complex_mixer: done, errors");
         $finish;
      end
   end

   // Drain side: random stalls per word, plus long hold-offs on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_asked != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done = holds_done + 1;
         end
         gap = recv_quiet ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offer one sample after a random gap; hold it until accepted
   task automatic send_sample(input bit restart, input logic [15:0] re,
                              input logic [15:0] im);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every word has come back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic program_step(input logic [STEP_W-1:0] step);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= step;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly random sample values, with full scale and near zero mixed in
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [STEP_W-1:0] step;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset step of zero: phase stays put
      send_sample(1'b0, 16'h4000, 16'h0000);
      send_sample(1'b0, 16'h7FFF, 16'h8000);

      // eighth-turn step walks all quadrants and the 45 degree points
      program_step(32'h2000_0000);
      send_sample(1'b1, 16'h7FFF, 16'h7FFF);
      send_sample(1'b0, 16'h7FFF, 16'h8000);
      send_sample(1'b0, 16'h8000, 16'h8000);
      send_sample(1'b0, 16'h8000, 16'h7FFF);
      send_sample(1'b0, 16'h0001, 16'hFFFF);
      send_sample(1'b0, 16'hFFFF, 16'h0001);
      send_sample(1'b0, 16'h0000, 16'h0000);
      send_sample(1'b0, 16'h7FFF, 16'h0000);
      send_sample(1'b0, 16'h0000, 16'h7FFF);

      // largest positive and negative steps, restart in the middle
      program_step(32'h7FFF_FFFF);
      send_sample(1'b1, 16'h8000, 16'h8000);
      send_sample(1'b0, 16'h7FFF, 16'h8000);
      send_sample(1'b0, 16'h1234, 16'hEDCB);
      program_step(32'h8000_0000);
      send_sample(1'b0, 16'h7FFF, 16'h7FFF);
      send_sample(1'b0, 16'h8000, 16'h0001);
      send_sample(1'b1, 16'h5555, 16'hAAAA);
      send_sample(1'b0, 16'hAAAA, 16'h5555);
      program_step(32'hFFFF_FFFF);
      send_sample(1'b0, 16'h7FFF, 16'h8000);
      send_sample(1'b1, 16'h8000, 16'h7FFF);

      // random phases, each with its own step and idling mix
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 4)
            0: step = $urandom;
            1: step = 32'($urandom_range(0, 4000)) - 32'd2000;
            2: begin
               case ($urandom_range(0, 3))
                  0:       step = 32'h7FFF_FFFF;
                  1:       step = 32'h8000_0000;
                  2:       step = 32'h0000_0000;
                  default: step = 32'hFFFF_FFFF;
               endcase
            end
            default: step = {4'($urandom_range(0, 15)), 28'h0};
         endcase
         program_step(step);
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         // fill the pipe against a stalled drain
         if (ph == 5) begin
            holds_asked = holds_asked + 1;
            send_quiet  = 1'b1;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 39) begin
               send_quiet = ($urandom_range(0, 2) == 0);
               recv_quiet = ($urandom_range(0, 2) == 0);
            end
            send_sample($urandom_range(0, 39) == 0, pick_value(), pick_value());
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("tb_nco_complex_mixer: done, clean");
      end else begin
         $display("tb_nco_complex_mixer: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ncm_pkg.sv
rtl/ncm_ram.sv
rtl/ncm_fill.sv
rtl/ncm_mixer.sv
rtl/nco_complex_mixer.sv
tb/nco_mixer_checker.sv
tb/tb_nco_complex_mixer.sv
